@@ hdl/tdd_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt to differential drive: shared definitions
// Fixed-point constants, register indexes and the structs that pass between
// the pipeline sections.
// ----------------------------------------------------------------------------
package tdd_pkg;

	localparam logic signed [15:0] CLAMP_HI = 16'sd160;
	localparam logic signed [15:0] CLAMP_LO = -16'sd160;
	localparam logic [8:0] THR_OFFSET = 9'd160;

	// |x| * 32768 / 160 is taken as (|x| * 52429) >> 8, exact for |x| <= 160.
	localparam logic [15:0] STEER_RECIP = 16'd52429;
	localparam int unsigned STEER_SHIFT = 8;
	// (y + 160) * 32768 / 320 is taken as (u * 838861) >> 13, exact for u <= 320.
	localparam logic [19:0] THR_RECIP = 20'd838861;
	localparam int unsigned THR_SHIFT = 13;

	localparam logic [16:0] ONE_Q15 = 17'd32768;
	localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
	localparam int unsigned LO_SHIFT = 28;
	localparam int unsigned HI_SHIFT = 15;
	localparam int unsigned DUTY_SHIFT = 15;

	localparam logic [15:0] MID_SPEED_RST = 16'd22938;
	localparam logic [15:0] REVERSE_SPEED_RST = 16'd26214;
	localparam logic [15:0] STOP_THRESHOLD_RST = 16'd3277;

	localparam logic [1:0] REG_MID_SPEED = 2'd0;
	localparam logic [1:0] REG_REVERSE_SPEED = 2'd1;
	localparam logic [1:0] REG_STOP_THRESHOLD = 2'd2;

	typedef struct packed {
		logic        vld;
		logic        low;
		logic [27:0] tt;
		logic [14:0] b;
		logic [15:0] lratio;
		logic [15:0] rratio;
	} sq_t;

	typedef struct packed {
		logic        vld;
		logic        rev;
		logic [15:0] speed;
		logic [15:0] lratio;
		logic [15:0] rratio;
	} spd_t;

endpackage

@@ hdl/tilt_to_differential_drive.sv @@
// ----------------------------------------------------------------------------
// Tilt to differential drive mapper
// Turns one accelerometer sample into two motor duties and a reverse flag.
// ----------------------------------------------------------------------------
// The slave channel takes one sample per transaction: accel_x and accel_y.
// The master channel delivers one result per sample: left and right duty in
// unsigned Q1.15 and the reversing flag. The user must write the three speed
// registers through the plain write port only while no sample is in flight;
// the block itself does not enforce this. The datapath is a five-stage
// pipeline: scaling, squaring, the two branch products, speed selection and
// the wheel multipliers. One sample can be accepted in every cycle while the
// output is not stalled; the throughput is then one transaction per cycle.
// When the receiver stalls, the whole pipeline holds: s_axis_tready falls as
// long as a result waits unaccepted at the output, and nothing is lost or
// repeated. Asynchronous reset empties the pipeline and loads the register
// defaults (0.7 mid-throttle speed, 0.8 reverse speed, 0.1 stop threshold).
// ----------------------------------------------------------------------------
module tilt_to_differential_drive (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // accel_x [15:0], accel_y [31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // left_pwm [15:0], right_pwm [31:16],
	                                   // reversing [32], zero [39:33]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] mid_speed_q, reverse_speed_q, stop_threshold_q;
	logic        en;
	logic [15:0] left_pwm, right_pwm;
	logic        reversing;

	tdd_pkg::sq_t  sq;
	tdd_pkg::spd_t spd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_speed_q <= tdd_pkg::MID_SPEED_RST;
			reverse_speed_q <= tdd_pkg::REVERSE_SPEED_RST;
			stop_threshold_q <= tdd_pkg::STOP_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tdd_pkg::REG_MID_SPEED: mid_speed_q <= cfg_data;
				tdd_pkg::REG_REVERSE_SPEED: reverse_speed_q <= cfg_data;
				tdd_pkg::REG_STOP_THRESHOLD: stop_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	tdd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_axis_tvalid),
		.accel_x (s_axis_tdata[15:0]),
		.accel_y (s_axis_tdata[31:16]),
		.sq      (sq)
	);

	tdd_speed u_speed (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.mid_speed      (mid_speed_q),
		.reverse_speed  (reverse_speed_q),
		.stop_threshold (stop_threshold_q),
		.sq             (sq),
		.spd            (spd)
	);

	tdd_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.spd       (spd),
		.out_vld   (m_axis_tvalid),
		.left_pwm  (left_pwm),
		.right_pwm (right_pwm),
		.reversing (reversing)
	);

	assign m_axis_tdata = {7'd0, reversing, right_pwm, left_pwm};

endmodule

@@ hdl/tdd_front.sv @@
// ----------------------------------------------------------------------------
// Tilt to differential drive: front section
// Clamps both axes, scales them to steer and throttle, then squares the
// throttle and forms the wheel ratios.
// ----------------------------------------------------------------------------
module tdd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [15:0]   accel_x,
	input  logic [15:0]   accel_y,
	output tdd_pkg::sq_t  sq
);

	logic signed [15:0] x_w, y_w;
	logic signed [8:0]  cx_w, cy_w;
	logic [8:0]         mag_w, u_w;
	logic [23:0]        steer_prod_w;
	logic [28:0]        thr_prod_w;

	logic        vld_s1, xpos_s1;
	logic [15:0] steer_s1, thr_s1;

	logic [15:0] ratio_w;
	tdd_pkg::sq_t sq_w;

	assign x_w = $signed(accel_x);
	assign y_w = $signed(accel_y);

	always_comb begin
		if (x_w > tdd_pkg::CLAMP_HI) begin
			cx_w = 9'(tdd_pkg::CLAMP_HI);
		end else if (x_w < tdd_pkg::CLAMP_LO) begin
			cx_w = 9'(tdd_pkg::CLAMP_LO);
		end else begin
			cx_w = 9'(x_w);
		end
		if (y_w > tdd_pkg::CLAMP_HI) begin
			cy_w = 9'(tdd_pkg::CLAMP_HI);
		end else if (y_w < tdd_pkg::CLAMP_LO) begin
			cy_w = 9'(tdd_pkg::CLAMP_LO);
		end else begin
			cy_w = 9'(y_w);
		end
		mag_w = cx_w[8] ? 9'(-cx_w) : 9'(cx_w);
		u_w = 9'(cy_w) + tdd_pkg::THR_OFFSET;
		steer_prod_w = 24'(mag_w[7:0]) * 24'(tdd_pkg::STEER_RECIP);
		thr_prod_w = 29'(u_w) * 29'(tdd_pkg::THR_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xpos_s1 <= !cx_w[8] && (cx_w != 9'sd0);
			steer_s1 <= 16'(steer_prod_w >> tdd_pkg::STEER_SHIFT);
			thr_s1 <= 16'(thr_prod_w >> tdd_pkg::THR_SHIFT);
		end
	end

	assign ratio_w = 16'(tdd_pkg::ONE_Q15 - 17'(steer_s1));

	always_comb begin
		sq_w.vld = vld_s1;
		sq_w.low = !thr_s1[15] && !thr_s1[14];
		sq_w.tt = 28'(thr_s1[13:0]) * 28'(thr_s1[13:0]);
		sq_w.b = 15'(tdd_pkg::ONE_Q15 - 17'(thr_s1));
		sq_w.lratio = xpos_s1 ? 16'(tdd_pkg::ONE_Q15) : ratio_w;
		sq_w.rratio = xpos_s1 ? ratio_w : 16'(tdd_pkg::ONE_Q15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq <= '0;
		end else if (en) begin
			sq <= sq_w;
		end
	end

endmodule

@@ hdl/tdd_speed.sv @@
// ----------------------------------------------------------------------------
// Tilt to differential drive: speed section
// Forms both branch products of the speed curve, selects and limits the
// speed and substitutes the reverse speed below the stop threshold.
// ----------------------------------------------------------------------------
module tdd_speed (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [15:0]   mid_speed,
	input  logic [15:0]   reverse_speed,
	input  logic [15:0]   stop_threshold,
	input  tdd_pkg::sq_t  sq,
	output tdd_pkg::spd_t spd
);

	logic signed [17:0] a_w;
	logic signed [15:0] b_w;

	logic               vld_s3, low_s3;
	logic [43:0]        lo_prod_s3;
	logic signed [33:0] hi_prod_s3;
	logic [15:0]        lratio_s3, rratio_s3;

	logic signed [34:0] prod2_w;
	logic signed [35:0] num_w;
	logic [20:0]        hi_w;
	logic [15:0]        hi_speed_w, speed_w;
	tdd_pkg::spd_t      spd_w;

	assign a_w = 18'sd32768 - $signed({2'b00, mid_speed});
	assign b_w = $signed({1'b0, sq.b});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			low_s3 <= sq.low;
			lo_prod_s3 <= 44'(mid_speed) * 44'(sq.tt);
			hi_prod_s3 <= 34'(a_w) * 34'(b_w);
			lratio_s3 <= sq.lratio;
			rratio_s3 <= sq.rratio;
		end
	end

	always_comb begin
		prod2_w = {hi_prod_s3, 1'b0};
		num_w = tdd_pkg::ONE_Q30 - 36'(prod2_w);
		if (num_w < 36'sd0) begin
			hi_w = 21'd0;
		end else begin
			hi_w = 21'(num_w >>> tdd_pkg::HI_SHIFT);
		end
		hi_speed_w = (hi_w > 21'd65535) ? 16'hFFFF : hi_w[15:0];
		speed_w = low_s3 ? 16'(lo_prod_s3 >> tdd_pkg::LO_SHIFT) : hi_speed_w;
	end

	always_comb begin
		spd_w.vld = vld_s3;
		spd_w.rev = speed_w < stop_threshold;
		spd_w.speed = (speed_w < stop_threshold) ? reverse_speed : speed_w;
		spd_w.lratio = lratio_s3;
		spd_w.rratio = rratio_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd <= '0;
		end else if (en) begin
			spd <= spd_w;
		end
	end

	a_rev_speed: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s3 && (speed_w < stop_threshold)
		|=> spd.rev && (spd.speed == $past(reverse_speed)))
		else $error("reverse speed not substituted");

	a_fwd_speed: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s3 |=> spd.rev || (spd.speed >= $past(stop_threshold)))
		else $error("forward speed below stop threshold");

	a_lo_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && low_s3 |-> ((lo_prod_s3 >> tdd_pkg::LO_SHIFT) <= 44'(mid_speed)))
		else $error("low branch speed overflow");

endmodule

@@ hdl/tdd_mix.sv @@
// ----------------------------------------------------------------------------
// Tilt to differential drive: wheel mixer
// Multiplies the speed by each wheel ratio and holds the result for the
// output channel.
// ----------------------------------------------------------------------------
module tdd_mix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tdd_pkg::spd_t spd,
	output logic          out_vld,
	output logic [15:0]   left_pwm,
	output logic [15:0]   right_pwm,
	output logic          reversing
);

	logic [31:0] lp_w, rp_w;

	assign lp_w = 32'(spd.speed) * 32'(spd.lratio);
	assign rp_w = 32'(spd.speed) * 32'(spd.rratio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= spd.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_pwm <= 16'(lp_w >> tdd_pkg::DUTY_SHIFT);
			right_pwm <= 16'(rp_w >> tdd_pkg::DUTY_SHIFT);
			reversing <= spd.rev;
		end
	end

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		en && spd.vld |=> (left_pwm <= $past(spd.speed)) && (right_pwm <= $past(spd.speed)))
		else $error("duty exceeds speed");

	a_outer_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		en && spd.vld |=> (left_pwm == $past(spd.speed)) || (right_pwm == $past(spd.speed)))
		else $error("no wheel at full speed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(left_pwm) && $stable(right_pwm) && $stable(reversing))
		else $error("held result changed");

endmodule
